// ===== design/fat12cte_pkg.sv =====
// fat12cte_pkg: shared widths, command and status codes, table constants
// and the entry position helper for the FAT12 cluster table engine.
// No dependencies.
package fat12cte_pkg;

	localparam int CMD_W      = 3;
	localparam int CLUSTER_W  = 12;
	localparam int BYTE_IDX_W = 13;
	localparam int DATA_W     = 8;
	localparam int VALUE_W    = 12;
	localparam int STATUS_W   = 2;
	localparam int ACTIVE_W   = 13;
	localparam int POS_W      = 14;
	localparam int WORD_W     = 16;

	localparam int TABLE_BYTES_DEF = 6144;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_ACTIVE_CLUSTERS = 1'b0;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_GET   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SET   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CHAIN = 3'd5;

	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FREE    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_STEP_LIMIT = 2'd2;

	localparam logic [CLUSTER_W-1:0] CHAIN_END    = 12'hff8;
	localparam logic [ACTIVE_W-1:0]  MAX_CLUSTERS = 13'd4096;
	localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET = 13'd4096;

	// first byte of a packed entry: c + c/2
	function automatic logic [POS_W-1:0] entry_pos(input logic [CLUSTER_W-1:0] c);
		return POS_W'(c) + POS_W'(c[CLUSTER_W-1:1]);
	endfunction

	// address width of one byte bank (even or odd bytes)
	function automatic int bank_addr_w(input int table_bytes);
		int depth;
		depth = (table_bytes + 1) >> 1;
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// ===== design/fat12cte_if.sv =====
// fat12cte_if: valid/ready stream interfaces for commands and results.
// Depends on fat12cte_pkg.
interface fat12cte_req_if;
	import fat12cte_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      cmd;
	logic [CLUSTER_W-1:0]  cluster;
	logic [CLUSTER_W-1:0]  next_value;
	logic [BYTE_IDX_W-1:0] byte_index;
	logic [DATA_W-1:0]     byte_data;

	modport source (output valid, cmd, cluster, next_value, byte_index, byte_data,
		input ready);
	modport sink (input valid, cmd, cluster, next_value, byte_index, byte_data,
		output ready);
endinterface

interface fat12cte_rsp_if;
	import fat12cte_pkg::*;
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  value;
	logic [STATUS_W-1:0] status;

	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

// ===== design/fat12_cluster_table_engine_top.sv =====
// Load byte and unknown commands finish as they are accepted; read byte, get and set
// go through the access state. Find-free: one entry per cycle on the bank read port,
// up to min(active_clusters, 4096) entries. Free-chain: each entry is read, then written
// back as zero; a zero start finishes as it is accepted. One command at a time; the result
// register lets the next command in while it waits. Reset clears control state and sets
// active_clusters to 4096; table bytes are not cleared and are undefined until loaded.
module fat12_cluster_table_engine_top #(
	parameter int TABLE_BYTES = fat12cte_pkg::TABLE_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	fat12cte_req_if.sink                        req,
	fat12cte_rsp_if.source                      rsp,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fat12cte_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [fat12cte_pkg::APB_DATA_W-1:0] pwdata,
	output logic [fat12cte_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready
);
	import fat12cte_pkg::*;

	localparam int BANK_DEPTH = (TABLE_BYTES + 1) >> 1;
	localparam int BANK_AW    = bank_addr_w(TABLE_BYTES);

	logic [ACTIVE_W-1:0]           active_clusters;
	logic [1:0]                    bank_we;
	logic [1:0][BANK_AW-1:0]       bank_waddr;
	logic [1:0][DATA_W-1:0]        bank_wdata;
	logic [1:0][BANK_AW-1:0]       bank_raddr;
	logic [1:0][DATA_W-1:0]        bank_rdata;

	fat12cte_apb_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.active_clusters (active_clusters)
	);

	fat12cte_seq #(
		.TABLE_BYTES (TABLE_BYTES),
		.BANK_AW     (BANK_AW)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.active_clusters (active_clusters),
		.req             (req),
		.rsp             (rsp),
		.bank_we         (bank_we),
		.bank_waddr      (bank_waddr),
		.bank_wdata      (bank_wdata),
		.bank_raddr      (bank_raddr),
		.bank_rdata      (bank_rdata)
	);

	// bank 0 holds even bytes, bank 1 odd bytes
	for (genvar b = 0; b < 2; b++) begin : g_bank
		fat12cte_ram #(
			.WIDTH  (DATA_W),
			.DEPTH  (BANK_DEPTH),
			.ADDR_W (BANK_AW)
		) u_ram (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (bank_waddr[b]),
			.wdata (bank_wdata[b]),
			.raddr (bank_raddr[b]),
			.rdata (bank_rdata[b])
		);
	end

endmodule

// ===== design/fat12cte_ram.sv =====
// fat12cte_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module fat12cte_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 2,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/fat12cte_apb_regs.sv =====
// fat12cte_apb_regs: APB register block holding active_clusters.
// Depends on fat12cte_pkg.
module fat12cte_apb_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [fat12cte_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [fat12cte_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [fat12cte_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready,
	output logic [fat12cte_pkg::ACTIVE_W-1:0]     active_clusters
);
	import fat12cte_pkg::*;

	logic [ACTIVE_W-1:0] active_q;
	logic                hit;

	// byte lanes within a word are ignored
	assign hit    = (paddr[APB_ADDR_W-1] == REG_ACTIVE_CLUSTERS);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (psel && penable && pwrite && hit) begin
			active_q <= pwdata[ACTIVE_W-1:0];
		end
	end

	assign prdata          = hit ? APB_DATA_W'(active_q) : '0;
	assign active_clusters = active_q;

endmodule

// ===== design/fat12cte_seq.sv =====
// fat12cte_seq: command sequencer with entry read-modify-write over two byte
// banks (even and odd bytes), find-free scan and chain free walk.
// Depends on fat12cte_pkg and fat12cte_if.
module fat12cte_seq #(
	parameter int TABLE_BYTES = fat12cte_pkg::TABLE_BYTES_DEF,
	parameter int BANK_AW     = fat12cte_pkg::bank_addr_w(TABLE_BYTES)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [fat12cte_pkg::ACTIVE_W-1:0]      active_clusters,
	fat12cte_req_if.sink                           req,
	fat12cte_rsp_if.source                         rsp,
	output logic [1:0]                             bank_we,
	output logic [1:0][BANK_AW-1:0]                bank_waddr,
	output logic [1:0][fat12cte_pkg::DATA_W-1:0]   bank_wdata,
	output logic [1:0][BANK_AW-1:0]                bank_raddr,
	input  logic [1:0][fat12cte_pkg::DATA_W-1:0]   bank_rdata
);
	import fat12cte_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_FIND,
		ST_CHAIN_RD,
		ST_CHAIN_WR,
		ST_HOLD
	} state_t;

	localparam logic [POS_W-1:0] TB_LIM = POS_W'(TABLE_BYTES);

	state_t                 state_q;
	logic [CMD_W-1:0]       cmd_q;
	logic [CLUSTER_W-1:0]   next_value_q;
	logic [CLUSTER_W-1:0]   cur_q;
	logic [ACTIVE_W-1:0]    steps_q;
	logic [ACTIVE_W-1:0]    icnt_q;
	logic                   rsp_valid_q;
	logic [VALUE_W-1:0]     rsp_value_q;
	logic [STATUS_W-1:0]    rsp_status_q;
	logic [VALUE_W-1:0]     hold_value_q;
	logic [STATUS_W-1:0]    hold_status_q;

	logic                   find_pend_s1;
	logic                   lo_bank_s1;
	logic                   lo_ok_s1;
	logic                   hi_ok_s1;
	logic                   odd_s1;
	logic [CLUSTER_W-1:0]   tag_s1;
	logic [1:0][BANK_AW-1:0] raddr_s1;

	logic                   acc;
	logic                   out_free;
	logic [ACTIVE_W-1:0]    lim;
	logic [CLUSTER_W-1:0]   rd_cl;
	logic [POS_W-1:0]       rd_pos;
	logic [POS_W-1:0]       rd_pos_p1;
	logic [POS_W-1:0]       ld_pos;
	logic                   ld_ok;
	logic [DATA_W-1:0]      lo_byte;
	logic [DATA_W-1:0]      hi_byte;
	logic [WORD_W-1:0]      word;
	logic [CLUSTER_W-1:0]   entry;
	logic [CLUSTER_W-1:0]   wr_val;
	logic [WORD_W-1:0]      new_word;
	logic                   ent_wr;
	logic                   load_wr;
	logic                   fin;
	logic [VALUE_W-1:0]     fin_value;
	logic [STATUS_W-1:0]    fin_status;
	logic                   issue_find;

	assign acc       = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign lim       = active_clusters[ACTIVE_W-1] ? MAX_CLUSTERS : active_clusters;
	assign req.ready = (state_q == ST_IDLE);

	// read address: from the walk registers in find and chain read, else from the request
	always_comb begin
		unique case (state_q)
			ST_FIND:     rd_cl = icnt_q[CLUSTER_W-1:0];
			ST_CHAIN_RD: rd_cl = cur_q;
			default:     rd_cl = req.cluster;
		endcase
		rd_pos = ((state_q == ST_IDLE) && (req.cmd == CMD_READ)) ?
			POS_W'(req.byte_index) : entry_pos(rd_cl);
		rd_pos_p1     = rd_pos + POS_W'(1);
		bank_raddr[0] = rd_pos_p1[BANK_AW:1];
		bank_raddr[1] = rd_pos[BANK_AW:1];
	end

	always_ff @(posedge clk) begin
		lo_bank_s1 <= rd_pos[0];
		lo_ok_s1   <= (rd_pos < TB_LIM);
		hi_ok_s1   <= (rd_pos_p1 < TB_LIM);
		odd_s1     <= rd_cl[0];
		tag_s1     <= rd_cl;
		raddr_s1   <= bank_raddr;
	end

	// entry assembly and merge; bytes beyond the table read as zero
	always_comb begin
		lo_byte  = lo_ok_s1 ? bank_rdata[lo_bank_s1] : '0;
		hi_byte  = hi_ok_s1 ? bank_rdata[~lo_bank_s1] : '0;
		word     = {hi_byte, lo_byte};
		entry    = odd_s1 ? word[WORD_W-1:4] : word[CLUSTER_W-1:0];
		wr_val   = (state_q == ST_ACCESS) ? next_value_q : '0;
		new_word = odd_s1 ? {wr_val, word[3:0]} : {word[WORD_W-1:CLUSTER_W], wr_val};
	end

	assign ent_wr  = ((state_q == ST_ACCESS) && (cmd_q == CMD_SET)) ||
		(state_q == ST_CHAIN_WR);
	assign load_wr = acc && (req.cmd == CMD_LOAD);
	assign ld_pos  = POS_W'(req.byte_index);
	assign ld_ok   = (ld_pos < TB_LIM);

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			if (ent_wr) begin
				bank_we[k]    = (lo_bank_s1 == 1'(k)) ? lo_ok_s1 : hi_ok_s1;
				bank_wdata[k] = (lo_bank_s1 == 1'(k)) ? new_word[DATA_W-1:0] :
					new_word[WORD_W-1:DATA_W];
				bank_waddr[k] = raddr_s1[k];
			end else begin
				bank_we[k]    = load_wr && ld_ok && (ld_pos[0] == 1'(k));
				bank_wdata[k] = req.byte_data;
				bank_waddr[k] = ld_pos[BANK_AW:1];
			end
		end
	end

	always_comb begin
		fin        = 1'b0;
		fin_value  = '0;
		fin_status = STATUS_OK;
		issue_find = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (req.cmd) inside
						CMD_READ, CMD_GET, CMD_SET, CMD_FIND: fin = 1'b0;
						CMD_CHAIN: fin = (req.cluster == '0);
						default:   fin = 1'b1;
					endcase
				end
			end
			ST_ACCESS: begin
				fin = 1'b1;
				if (cmd_q == CMD_READ)
					fin_value = VALUE_W'(lo_byte);
				else if (cmd_q == CMD_GET)
					fin_value = entry;
			end
			ST_FIND: begin
				if (find_pend_s1 && (entry == '0)) begin
					fin       = 1'b1;
					fin_value = tag_s1;
				end else if (icnt_q < lim) begin
					issue_find = 1'b1;
				end else begin
					fin        = 1'b1;
					fin_status = STATUS_NO_FREE;
				end
			end
			ST_CHAIN_RD: begin
				if (cur_q >= CHAIN_END) begin
					fin = 1'b1;
				end else if (steps_q >= lim) begin
					fin        = 1'b1;
					fin_status = STATUS_STEP_LIMIT;
				end
			end
			default: fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cmd_q         <= CMD_LOAD;
			next_value_q  <= '0;
			cur_q         <= '0;
			steps_q       <= '0;
			icnt_q        <= '0;
			find_pend_s1  <= 1'b0;
			rsp_valid_q   <= 1'b0;
			rsp_value_q   <= '0;
			rsp_status_q  <= STATUS_OK;
			hold_value_q  <= '0;
			hold_status_q <= STATUS_OK;
		end else begin
			if (rsp.ready)
				rsp_valid_q <= 1'b0;
			if (fin) begin
				if (out_free) begin
					rsp_valid_q  <= 1'b1;
					rsp_value_q  <= fin_value;
					rsp_status_q <= fin_status;
					state_q      <= ST_IDLE;
				end else begin
					hold_value_q  <= fin_value;
					hold_status_q <= fin_status;
					state_q       <= ST_HOLD;
				end
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (acc) begin
							cmd_q        <= req.cmd;
							next_value_q <= req.next_value;
							cur_q        <= req.cluster;
							steps_q      <= '0;
							icnt_q       <= '0;
							find_pend_s1 <= 1'b0;
							if (req.cmd == CMD_FIND)
								state_q <= ST_FIND;
							else if (req.cmd == CMD_CHAIN)
								state_q <= ST_CHAIN_RD;
							else
								state_q <= ST_ACCESS;
						end
					end
					ST_FIND: begin
						find_pend_s1 <= issue_find;
						if (issue_find)
							icnt_q <= icnt_q + ACTIVE_W'(1);
					end
					ST_CHAIN_RD: state_q <= ST_CHAIN_WR;
					ST_CHAIN_WR: begin
						cur_q   <= entry;
						steps_q <= steps_q + ACTIVE_W'(1);
						state_q <= ST_CHAIN_RD;
					end
					ST_HOLD: begin
						if (out_free) begin
							rsp_valid_q  <= 1'b1;
							rsp_value_q  <= hold_value_q;
							rsp_status_q <= hold_status_q;
							state_q      <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.value  = rsp_value_q;
	assign rsp.status = rsp_status_q;

endmodule

// ===== design/fat12cte_chk.sv =====
// fat12cte_chk: port-level assertions on the result channel, bound to the top level.
// Depends on fat12cte_pkg and fat12_cluster_table_engine_top.
module fat12cte_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [fat12cte_pkg::VALUE_W-1:0]  rsp_value,
	input logic [fat12cte_pkg::STATUS_W-1:0] rsp_status
);
	import fat12cte_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_status))
		else $error("result payload changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_NO_FREE) ||
			(rsp_status == STATUS_STEP_LIMIT))
		else $error("undefined status code");

	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_value == '0))
		else $error("nonzero value with failing status");

endmodule

bind fat12_cluster_table_engine_top fat12cte_chk u_fat12cte_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_value  (rsp.value),
	.rsp_status (rsp.status)
);
